// File: hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

    localparam int DATA_W          = 32;
    localparam int CMD_W           = 4;
    localparam int FRACTION_BITS_D = 14;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TO_FIXED     = 4'd0,
        CMD_TO_INT_TRUNC = 4'd1,
        CMD_TO_INT_ROUND = 4'd2,
        CMD_ADD          = 4'd3,
        CMD_SUB          = 4'd4,
        CMD_ADD_INT      = 4'd5,
        CMD_SUB_INT      = 4'd6,
        CMD_MUL          = 4'd7,
        CMD_MUL_INT      = 4'd8,
        CMD_DIV          = 4'd9,
        CMD_DIV_INT      = 4'd10
    } cmd_t;

    // class of work picked by the front end
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SHR,
        OP_MUL,
        OP_DIV,
        OP_DZ
    } op_t;

    // classified word handed from front to back
    typedef struct packed {
        op_t                op;
        logic               mul_shift;
        logic               div_shift;
        logic [DATA_W-1:0]  x;
        logic [DATA_W-1:0]  y;
    } work_t;

    // input channel word
    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } alu_in_t;

    // output channel word
    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     divide_by_zero;
    } alu_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/fpa_if.sv
// ----------------------------------------------------------------------------
// fpa_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpa_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Decodes the command and forms the operands for the back end, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_D
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [CMD_W-1:0]   command,
    input  wire logic [DATA_W-1:0]  operand_a,
    input  wire logic [DATA_W-1:0]  operand_b,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output work_t                   out_work
);

    localparam logic [DATA_W-1:0] HALF = DATA_W'(1) << (FRACTION_BITS - 1);

    logic  valid_reg;
    work_t work_reg, work_next;
    logic [DATA_W-1:0] b_scaled;

    assign b_scaled  = operand_b << FRACTION_BITS;
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    // classification
    always_comb
    begin
        work_next           = '0;
        work_next.op        = OP_NONE;
        work_next.x         = operand_a;
        work_next.y         = operand_b;
        unique case (command)
            CMD_TO_FIXED:
            begin
                work_next.op = OP_ADD;
                work_next.x  = '0;
                work_next.y  = b_scaled;
            end
            CMD_TO_INT_TRUNC: work_next.op = OP_SHR;
            CMD_TO_INT_ROUND:
            begin
                // bias toward zero-away, shift unit handles sign fix
                work_next.op = OP_SHR;
                work_next.y  = ($signed(operand_a) > 0) ? HALF : -HALF;
            end
            CMD_ADD: work_next.op = OP_ADD;
            CMD_SUB:
            begin
                work_next.op = OP_ADD;
                work_next.y  = -operand_b;
            end
            CMD_ADD_INT:
            begin
                work_next.op = OP_ADD;
                work_next.y  = b_scaled;
            end
            CMD_SUB_INT:
            begin
                work_next.op = OP_ADD;
                work_next.y  = -b_scaled;
            end
            CMD_MUL:
            begin
                work_next.op        = OP_MUL;
                work_next.mul_shift = 1'b1;
            end
            CMD_MUL_INT: work_next.op = OP_MUL;
            CMD_DIV:
            begin
                work_next.op        = (operand_b == '0) ? OP_DZ : OP_DIV;
                work_next.div_shift = 1'b1;
            end
            CMD_DIV_INT: work_next.op = (operand_b == '0) ? OP_DZ : OP_DIV;
            default: work_next.op = OP_NONE;
        endcase
        if (command == CMD_TO_INT_TRUNC)
        begin
            work_next.y = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fpa_queue.sv
// ----------------------------------------------------------------------------
// fpa_queue
// Short register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_queue
    import fpa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  work_t      in_work,
    output logic       out_valid,
    input  wire logic  out_ready,
    output work_t      out_work
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    work_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   count_reg;
    logic push, pop;

    assign in_ready  = count_reg != (AW+1)'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_work  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_work;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fpa_divider.sv
// ----------------------------------------------------------------------------
// fpa_divider
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_divider #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [NW-1:0]  num,
    input  wire logic [DW-1:0]  den,
    input  wire logic           neg,
    output logic                out_valid,
    output logic [NW-1:0]       quo
);

    // registers at the output of each stage
    logic          v_reg [NW];
    logic [NW-1:0] q_reg [NW];
    logic [NW-1:0] r_reg [NW];
    logic [DW-1:0] d_reg [NW];
    logic          n_reg [NW];

    // one stage per quotient bit
    for (genvar s = 0; s < NW; s++)
    begin : g_stage
        logic          v_in;
        logic [NW-1:0] q_in;
        logic [NW-1:0] r_in;
        logic [DW-1:0] d_in;
        logic          n_in;
        logic [NW:0]   trial;
        logic [NW-1:0] rem_sh;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign q_in = num;
            assign r_in = '0;
            assign d_in = den;
            assign n_in = neg;
        end
        else
        begin : g_next
            assign v_in = v_reg[s-1];
            assign q_in = q_reg[s-1];
            assign r_in = r_reg[s-1];
            assign d_in = d_reg[s-1];
            assign n_in = n_reg[s-1];
        end

        assign rem_sh = {r_in[NW-2:0], q_in[NW-1]};
        assign trial  = {1'b0, rem_sh} - {{(NW+1-DW){1'b0}}, d_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s] <= trial[NW] ? rem_sh : trial[NW-1:0];
                q_reg[s] <= {q_in[NW-2:0], !trial[NW]};
                d_reg[s] <= d_in;
                n_reg[s] <= n_in;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quo       = n_reg[NW-1] ? -q_reg[NW-1] : q_reg[NW-1];

endmodule

`default_nettype wire

// File: hw/rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Executes classified words: add, shift, multiply or divide, then result.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_back
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_D
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  work_t                   in_work,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [DATA_W-1:0]       result,
    output logic                    divide_by_zero
);

    localparam int WW = 2 * DATA_W;

    // pipeline moves as one block; stalls when the output is held
    logic en;
    logic ovalid_reg;
    assign en        = !ovalid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = ovalid_reg;

    // stage 1: 32x32 signed product or simple result
    logic              s1_valid_reg;
    work_t             s1_work_reg;
    logic [WW-1:0]     prod_reg;
    logic [DATA_W-1:0] simple_reg;
    logic [WW-1:0]     sum_w;
    assign sum_w = {{DATA_W{in_work.x[DATA_W-1]}}, in_work.x}
                 + {{DATA_W{in_work.y[DATA_W-1]}}, in_work.y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid && in_work.op != OP_DIV;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_work_reg <= in_work;
            prod_reg    <= WW'($signed(in_work.x) * $signed(in_work.y));
            priority case (in_work.op)
                OP_ADD:  simple_reg <= sum_w[DATA_W-1:0];
                // truncating arithmetic shift toward zero of the 64-bit sum
                OP_SHR:  simple_reg <= DATA_W'(($signed(sum_w)
                            + (sum_w[WW-1] ? (WW'(1) << FRACTION_BITS) - 1'b1 : '0))
                            >>> FRACTION_BITS);
                default: simple_reg <= '0;
            endcase
        end
    end

    // divider path, magnitudes with sign fixed at the end
    logic [WW-1:0]     dnum_s, dnum_mag;
    logic [DATA_W-1:0] dden_mag;
    logic [WW-1:0]     dquo;
    logic              dvalid, dneg;
    assign dnum_s   = in_work.div_shift
                    ? {{DATA_W{in_work.x[DATA_W-1]}}, in_work.x} << FRACTION_BITS
                    : {{DATA_W{in_work.x[DATA_W-1]}}, in_work.x};
    assign dnum_mag = dnum_s[WW-1] ? -dnum_s : dnum_s;
    assign dden_mag = in_work.y[DATA_W-1] ? -in_work.y : in_work.y;
    assign dneg     = dnum_s[WW-1] ^ in_work.y[DATA_W-1];

    fpa_divider #(.NW(WW), .DW(DATA_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid && in_work.op == OP_DIV),
        .num      (dnum_mag),
        .den      (dden_mag),
        .neg      (dneg),
        .out_valid(dvalid),
        .quo      (dquo)
    );

    // stage 2: product scaling, then delay line to the divider's depth
    logic [DATA_W-1:0] s2_res;
    logic              s2_dz;
    logic [WW-1:0]     pshift;
    assign pshift = $signed(prod_reg)
                  + (prod_reg[WW-1] ? (WW'(1) << FRACTION_BITS) - 1'b1 : '0);
    always_comb
    begin
        s2_dz = s1_work_reg.op == OP_DZ;
        unique case (s1_work_reg.op)
            OP_MUL:  s2_res = s1_work_reg.mul_shift
                            ? DATA_W'($signed(pshift) >>> FRACTION_BITS)
                            : prod_reg[DATA_W-1:0];
            OP_ADD, OP_SHR: s2_res = simple_reg;
            default: s2_res = '0;
        endcase
    end

    localparam int LAT = WW - 1;
    logic [LAT-1:0]    dl_v_reg;
    logic [DATA_W:0]   dl_d_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_v_reg <= '0;
        end
        else if (en)
        begin
            dl_v_reg <= {dl_v_reg[LAT-2:0], s1_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_d_reg[0] <= {s2_dz, s2_res};
            for (int i = 1; i < LAT; i++)
            begin
                dl_d_reg[i] <= dl_d_reg[i-1];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (en)
        begin
            ovalid_reg <= dvalid || dl_v_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dvalid)
            begin
                result         <= dquo[DATA_W-1:0];
                divide_by_zero <= 1'b0;
            end
            else
            begin
                result         <= dl_d_reg[LAT-1][DATA_W-1:0];
                divide_by_zero <= dl_d_reg[LAT-1][DATA_W];
            end
        end
    end

    // both paths never deliver in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(dvalid && dl_v_reg[LAT-1]))
        else $error("divider and bypass collide");
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ready |=> ovalid_reg && $stable(result))
        else $error("held result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && divide_by_zero |-> result == '0)
        else $error("zero divisor with nonzero result");

endmodule

`default_nettype wire

// File: hw/rtl/fixed_point_17_14_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu
// Signed Q17.14 fixed-point ALU with a decoupled decode front and execute back.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the output is not stalled and
// returns one result word per input, in order. Every command passes a path as
// deep as the 64-stage pipelined divider to the result register, plus any
// time spent in the two-entry queue. A stalled output holds the whole back
// end; the queue and front register absorb three further words.
`default_nettype none

module fixed_point_17_14_alu
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_D
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fpa_if.sink       in_ch,
    fpa_if.source     out_ch
);

    logic  f_valid, f_ready, q_valid, q_ready;
    work_t f_work, q_work;

    fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .command  (in_ch.data.command),
        .operand_a(in_ch.data.operand_a),
        .operand_b(in_ch.data.operand_b),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_work (f_work)
    );

    fpa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_work  (f_work),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_work (q_work)
    );

    fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_work       (q_work),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .result        (out_ch.data.result),
        .divide_by_zero(out_ch.data.divide_by_zero)
    );

endmodule

`default_nettype wire

// File: dv/fixed_point_17_14_alu_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_17_14_alu_tb
// Self-checking bench for the Q17.14 fixed-point ALU: a directed table of
// corner cases, then random words with random idling on both channels, each
// result checked against its typed answer or a behavioral model of the eleven commands.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_17_14_alu_tb
    import fpa_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC       = FRACTION_BITS_D;
    localparam int  N_RANDOM   = 600;
    localparam int  DRAIN_WAIT = 100;
    localparam int  CYCLE_MAX  = 300000;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

    // one directed row: word plus an optional typed answer
    typedef struct {
        alu_in_t  word;
        bit       typed;
        alu_out_t answer;
    } vector_t;

    logic clk;
    logic rst_n;
    int   cycles;
    int   errors;
    bit   sender_burst;
    bit   receiver_burst;

    fpa_if #(.payload_t(alu_in_t))  in_ch ();
    fpa_if #(.payload_t(alu_out_t)) out_ch ();

    alu_out_t result_q[$];
    vector_t  vector_q[$];
    vector_t  vectors[$];

    fixed_point_17_14_alu dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // behavioral model of one command
    function automatic alu_out_t alu_compute(alu_in_t w);
        alu_out_t         r;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] scale;
        logic signed [63:0] wide;
        a     = 64'(w.operand_a);
        b     = 64'(w.operand_b);
        scale = 64'sd1 <<< FRAC;
        wide  = 64'sd0;
        r     = '0;
        case (w.command)
            CMD_TO_FIXED:     wide = b <<< FRAC;
            CMD_TO_INT_TRUNC: wide = a / scale;
            CMD_TO_INT_ROUND:
            begin
                if (a > 0)
                    wide = (a + scale / 2) / scale;
                else
                    wide = (a - scale / 2) / scale;
            end
            CMD_ADD:          wide = a + b;
            CMD_SUB:          wide = a - b;
            CMD_ADD_INT:      wide = a + (b <<< FRAC);
            CMD_SUB_INT:      wide = a - (b <<< FRAC);
            CMD_MUL:          wide = (a * b) / scale;
            CMD_MUL_INT:      wide = a * b;
            CMD_DIV:
            begin
                if (b == 0)
                    r.divide_by_zero = 1'b1;
                else
                    wide = (a * scale) / b;
            end
            CMD_DIV_INT:
            begin
                if (b == 0)
                    r.divide_by_zero = 1'b1;
                else
                    wide = a / b;
            end
            default:          wide = 64'sd0;
        endcase
        r.result = wide[31:0];
        return r;
    endfunction

    function automatic vector_t row(logic [CMD_W-1:0] c, logic [31:0] a, logic [31:0] b,
                                    bit typed = 0, logic [31:0] res = '0, logic dz = 1'b0);
        vector_t v;
        v.word   = '{command: c, operand_a: a, operand_b: b};
        v.typed  = typed;
        v.answer = '{result: res, divide_by_zero: dz};
        return v;
    endfunction

    // operand biased toward edges and small values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return 32'(int'($urandom_range(0, 64)) - 32);
            3:       return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            4:       return 32'($urandom_range(0, 3)) << FRAC;
            default: return $urandom;
        endcase
    endfunction

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX)
        begin
            $display("%0t timeout", $time);
            $display("fixed_point_17_14_alu test failed");
            $finish;
        end
    end

    // input monitor: record the answer of each accepted word
    always @(posedge clk)
    begin
        vector_t v;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            v = vector_q.pop_front();
            if (v.word !== in_ch.data)
            begin
                $display("%0t stimulus order lost: expected %h actual %h",
                         $time, v.word, in_ch.data);
                errors++;
            end
            result_q.push_back(v.typed ? v.answer : alu_compute(in_ch.data));
        end
    end

    // output monitor: compare field by field
    always @(posedge clk)
    begin
        alu_out_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t unexpected word: actual %h", $time, out_ch.data);
                errors++;
            end
            else
            begin
                e = result_q.pop_front();
                if (out_ch.data.result !== e.result)
                begin
                    $display("%0t result mismatch: expected %h actual %h",
                             $time, e.result, out_ch.data.result);
                    errors++;
                end
                if (out_ch.data.divide_by_zero !== e.divide_by_zero)
                begin
                    $display("%0t divide_by_zero mismatch: expected %b actual %b",
                             $time, e.divide_by_zero, out_ch.data.divide_by_zero);
                    errors++;
                end
            end
        end
    end

    // receiver with random stalls
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = receiver_burst ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    task automatic send_word(vector_t v);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vector_q.push_back(v);
        in_ch.valid <= 1'b1;
        in_ch.data  <= v.word;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        vector_t v;
        int      c;
        cycles         = 0;
        errors         = 0;
        sender_burst   = 0;
        receiver_burst = 0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;

        // directed corners
        vectors.push_back(row(CMD_TO_FIXED, 0, 1, 1, 32'd16384));
        vectors.push_back(row(CMD_TO_FIXED, 0, 0, 1, 32'd0));
        vectors.push_back(row(CMD_TO_FIXED, 0, S_MAX));
        vectors.push_back(row(CMD_TO_INT_TRUNC, -1, 0, 1, 32'd0));
        vectors.push_back(row(CMD_TO_INT_TRUNC, S_MIN, 0, 1, -32'sd131072));
        vectors.push_back(row(CMD_TO_INT_ROUND, 8192, 0, 1, 32'd1));
        vectors.push_back(row(CMD_TO_INT_ROUND, -8192, 0, 1, -32'sd1));
        vectors.push_back(row(CMD_TO_INT_ROUND, 0, 0, 1, 32'd0));
        vectors.push_back(row(CMD_TO_INT_ROUND, S_MAX, 0, 1, 32'd131072));
        vectors.push_back(row(CMD_TO_INT_ROUND, S_MIN, 0, 1, -32'sd131072));
        vectors.push_back(row(CMD_ADD, S_MAX, 1, 1, S_MIN));
        vectors.push_back(row(CMD_SUB, S_MIN, 1, 1, S_MAX));
        vectors.push_back(row(CMD_ADD_INT, 32'h1234_5678, -5));
        vectors.push_back(row(CMD_SUB_INT, S_MIN, S_MAX));
        vectors.push_back(row(CMD_MUL, 16384, 16384, 1, 32'd16384));
        vectors.push_back(row(CMD_MUL, S_MIN, S_MIN, 1, 32'd0));
        vectors.push_back(row(CMD_MUL_INT, S_MAX, S_MAX));
        vectors.push_back(row(CMD_DIV, 16384, 0, 1, 32'd0, 1'b1));
        vectors.push_back(row(CMD_DIV, S_MIN, -1));
        vectors.push_back(row(CMD_DIV, -49152, 32768));
        vectors.push_back(row(CMD_DIV_INT, 7, 0, 1, 32'd0, 1'b1));
        vectors.push_back(row(CMD_DIV_INT, S_MIN, -1, 1, S_MIN));
        vectors.push_back(row(CMD_DIV_INT, -7, 2, 1, -32'sd3));
        vectors.push_back(row(4'd11, S_MAX, 0, 1, 32'd0));
        vectors.push_back(row(4'd15, 5, 0, 1, 32'd0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
            send_word(vectors[i]);

        // random words, with stretches of back-to-back traffic
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 100 == 0)
            begin
                sender_burst   <= ($urandom_range(0, 2) == 0);
                receiver_burst <= ($urandom_range(0, 2) == 0);
            end
            c = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 10);
            v = row(CMD_W'(c), pick_operand(), pick_operand());
            if ((c == CMD_DIV || c == CMD_DIV_INT) && $urandom_range(0, 7) == 0)
                v.word.operand_b = '0;
            send_word(v);
        end
        in_ch.valid <= 1'b0;

        // drain
        while (result_q.size() != 0 || vector_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("fixed_point_17_14_alu test passed");
        else
            $display("fixed_point_17_14_alu test failed");
        $finish;
    end

endmodule

`default_nettype wire
